// ===== rtl/core/lgs_pkg.sv =====
// Package for the lidar gap steering core: item types, codes, widths and
// controller states. Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package lgs_pkg;

  // Iterative divider sizing.
  localparam int DIVIDEND_W = 48;
  localparam int DIVISOR_W  = 32;
  localparam int DIV_CNT_W  = 6;

  localparam int COUNT_W = 13;
  localparam logic [COUNT_W-1:0] COUNT_FULL = '1;
  localparam logic [13:0] SPEED_MAX = 14'd10000;
  localparam logic [10:0] STEER_LIM = 11'd1571;

  // Register indexes on the configuration port.
  localparam logic [2:0] CFG_LOGIC_EN    = 3'd0;
  localparam logic [2:0] CFG_REQ_ODOM    = 3'd1;
  localparam logic [2:0] CFG_CRUISE      = 3'd2;
  localparam logic [2:0] CFG_STOP_DIST   = 3'd3;
  localparam logic [2:0] CFG_SLOW_DIST   = 3'd4;
  localparam logic [2:0] CFG_MAX_STEER   = 3'd5;
  localparam logic [2:0] CFG_STEER_GAIN  = 3'd6;

  // Reason codes of a command.
  localparam logic [2:0] RSN_LOGIC_OFF  = 3'd0;
  localparam logic [2:0] RSN_SCAN_STALE = 3'd1;
  localparam logic [2:0] RSN_ODOM_STALE = 3'd2;
  localparam logic [2:0] RSN_NO_ENABLE  = 3'd3;
  localparam logic [2:0] RSN_FAULT      = 3'd4;
  localparam logic [2:0] RSN_OBSTACLE   = 3'd5;
  localparam logic [2:0] RSN_GAP_DRIVE  = 3'd6;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [15:0]       range_mm;
    logic signed [15:0] angle_cdeg;
    logic              range_usable;
    logic [13:0]       clear_mm;
    logic              last_sample;
    logic              mode_autonomous;
    logic              drive_enabled;
    logic              scan_recent;
    logic              odom_recent;
    logic              veh_fault;
  } in_item_t;

  typedef struct packed {
    logic [13:0]        speed_mm_s;
    logic signed [11:0] steering_mrad;
    logic [2:0]         reason_code;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_ACC,
    OP_GATE,
    OP_DIVL,
    OP_WAITL,
    OP_DIVR,
    OP_WAITR,
    OP_COMMIT,
    OP_STEER_MUL,
    OP_STEER_DIV,
    OP_STEER_WAIT,
    OP_SPEED_MUL1,
    OP_SPEED_MUL2,
    OP_SPEED_DIV,
    OP_SPEED_WAIT
  } op_t;

  // OP_LOAD_OUT is carried separately so the enum stays within four bits.
  typedef struct packed {
    op_t  op;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic last;
    logic mode;
    logic gate_stop;
    logic div_done;
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_DIVL,
    S_WAITL,
    S_DIVR,
    S_WAITR,
    S_COMMIT,
    S_STEER_MUL,
    S_STEER_DIV,
    S_STEER_WAIT,
    S_SPEED_MUL1,
    S_SPEED_MUL2,
    S_SPEED_DIV,
    S_SPEED_WAIT,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/lidar_gap_steering_core.sv =====
// Top level of the lidar gap steering core: joins the controller and the
// datapath. Uses lgs_pkg, lgs_ctrl and lgs_datapath.
`timescale 1ns / 1ps
`default_nettype none
// The core takes one item at a time over a valid/ready input channel. A scan
// sample is captured and then added to the accumulators before the core is
// ready again; the last sample of a scan also forms the two rounded sector
// averages and commits the front minimum. A control tick that is dropped for
// mode returns straight to idle, and one that a gate stops goes to the emit
// step and waits there for the output register; a tick that drives runs the
// steering and speed arithmetic before that same wait. The long paths are set
// by the single shared restoring divider, which resolves one quotient bit per
// cycle over 48 bits, and the divisions go through it in turn. A result sits
// in an output register, so the next item is accepted while a command still
// waits for the consumer. Configuration registers are written through the
// plain write port while the core is idle; the user must keep to this, as the core does not enforce it.
module lidar_gap_steering_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire lgs_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output lgs_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata
);
  import lgs_pkg::*;

  // Commands flow down to the datapath, status flows back up.
  cmd_t    cmd;
  status_t status;

  lgs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lgs_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/core/lgs_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on lgs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lgs_div (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [lgs_pkg::DIVIDEND_W-1:0]  dividend,
  input  wire logic [lgs_pkg::DIVISOR_W-1:0]   divisor,
  output logic                                 done,
  output logic [lgs_pkg::DIVIDEND_W-1:0]       quotient
);
  import lgs_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIVIDEND_W - 1);

  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dvs_r;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W+1:0]  sub;

  // The partial remainder always stays below the divisor, so it fits in
  // the divisor width.
  always_comb begin
    rem_sh   = {rem_r, quo_r[DIVIDEND_W-1]};
    sub      = {1'b0, rem_sh} - {2'b00, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = LAST_STEP;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIVIDEND_W-2:0], ~sub[DIVISOR_W+1]};
      rem_nxt = sub[DIVISOR_W+1] ? rem_sh[DIVISOR_W-1:0] : sub[DIVISOR_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== rtl/core/lgs_datapath.sv =====
// Datapath: configuration registers, scan accumulators, committed sector
// results, steering and speed arithmetic, output register. Uses lgs_pkg, lgs_div.
`timescale 1ns / 1ps
`default_nettype none
module lgs_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lgs_pkg::in_item_t in_data,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_wdata,
  input  wire lgs_pkg::cmd_t     cmd,
  output lgs_pkg::status_t       status,
  output lgs_pkg::out_item_t     out_data
);
  import lgs_pkg::*;

  // Configuration.
  logic        logic_en_r, req_odom_r;
  logic [13:0] cruise_r;
  logic [15:0] stop_r, slow_cfg_r;
  logic [10:0] max_steer_r;
  logic [11:0] gain_r;

  // Scan state.
  logic [15:0]        fmin_r;
  logic               fseen_r;
  logic [31:0]        lsum_r, rsum_r;
  logic [COUNT_W-1:0] lcnt_r, rcnt_r;
  logic [15:0]        front_r;
  logic               fvalid_r;
  logic [15:0]        lclr_r, rclr_r;

  // Work registers.
  in_item_t  item_r;
  logic      neg_r;
  logic [16:0] scale_r;
  logic [27:0] prod_r;
  logic [10:0] mag_r;
  logic [30:0] p1_r;
  logic [16:0] d1_r;
  logic [13:0] n2_r, d2_r;
  logic [44:0] p2_r;
  logic [30:0] dd_r;
  out_item_t res_r, out_r;

  logic [DIVIDEND_W-1:0] div_dividend, div_q;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic                  div_start, div_done;

  lgs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sample classification.
  logic signed [15:0] ang;
  logic [15:0] val;
  logic in_front, in_left, in_right;
  always_comb begin
    ang      = item_r.angle_cdeg;
    val      = item_r.range_usable ? item_r.range_mm : {2'b00, item_r.clear_mm};
    in_front = (ang >= -16'sd1500) && (ang <= 16'sd1500) && item_r.range_usable;
    in_left  = (ang >= 16'sd1000) && (ang <= 16'sd7000) && (lcnt_r != COUNT_FULL);
    in_right = (ang >= -16'sd7000) && (ang <= -16'sd1000) && (rcnt_r != COUNT_FULL);
  end

  // Gate chain of a tick.
  logic [2:0] reason;
  always_comb begin
    if (!logic_en_r) begin
      reason = RSN_LOGIC_OFF;
    end else if (!item_r.scan_recent) begin
      reason = RSN_SCAN_STALE;
    end else if (req_odom_r && !item_r.odom_recent) begin
      reason = RSN_ODOM_STALE;
    end else if (!item_r.drive_enabled) begin
      reason = RSN_NO_ENABLE;
    end else if (item_r.veh_fault) begin
      reason = RSN_FAULT;
    end else if (fvalid_r && (front_r <= stop_r)) begin
      reason = RSN_OBSTACLE;
    end else begin
      reason = RSN_GAP_DRIVE;
    end
  end

  // Steering front end.
  logic [16:0] lr_sum, scale;
  logic        neg;
  logic [15:0] diff;
  always_comb begin
    lr_sum = {1'b0, lclr_r} + {1'b0, rclr_r};
    scale  = (lr_sum > 17'd500) ? lr_sum : 17'd500;
    neg    = rclr_r > lclr_r;
    diff   = neg ? (rclr_r - lclr_r) : (lclr_r - rclr_r);
  end

  // Speed factors.
  logic [16:0] slow, stop_ext, n1, d1;
  logic [13:0] m5, three_mag, num2, n2, d2;
  always_comb begin
    stop_ext  = {1'b0, stop_r};
    slow      = ({1'b0, slow_cfg_r} > stop_ext + 17'd10) ? {1'b0, slow_cfg_r}
                                                          : stop_ext + 17'd10;
    if (fvalid_r && ({1'b0, front_r} < slow)) begin
      n1 = {1'b0, front_r} - stop_ext;
      d1 = slow - stop_ext;
    end else begin
      n1 = 17'd1;
      d1 = 17'd1;
    end
    m5        = 14'(max_steer_r) * 14'd5;
    three_mag = 14'(mag_r) * 14'd3;
    num2      = m5 - three_mag;
    n2 = 14'd1;
    d2 = 14'd1;
    if (max_steer_r != '0) begin
      if ({num2, 2'b00} < {2'b00, m5}) begin
        n2 = 14'd1;
        d2 = 14'd4;
      end else begin
        n2 = num2;
        d2 = m5;
      end
    end
  end

  // Divider operand selection.
  logic [37:0] steer_num;
  always_comb begin
    steer_num    = 38'(prod_r) * 38'd1000;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (cmd.op)
      OP_DIVL: begin
        div_start    = 1'b1;
        div_dividend = DIVIDEND_W'(lsum_r) + DIVIDEND_W'(lcnt_r >> 1);
        div_divisor  = DIVISOR_W'(lcnt_r);
      end
      OP_DIVR: begin
        div_start    = 1'b1;
        div_dividend = DIVIDEND_W'(rsum_r) + DIVIDEND_W'(rcnt_r >> 1);
        div_divisor  = DIVISOR_W'(rcnt_r);
      end
      OP_STEER_DIV: begin
        div_start    = 1'b1;
        div_dividend = DIVIDEND_W'(steer_num) + DIVIDEND_W'({scale_r, 7'd0});
        div_divisor  = DIVISOR_W'({scale_r, 8'd0});
      end
      OP_SPEED_DIV: begin
        div_start    = 1'b1;
        div_dividend = DIVIDEND_W'(p2_r) + DIVIDEND_W'(dd_r >> 1);
        div_divisor  = DIVISOR_W'(dd_r);
      end
      default: begin
      end
    endcase
  end

  // Final command values after the speed division.
  logic [13:0] spd_sat;
  logic [10:0] steer_abs;
  always_comb begin
    spd_sat   = (div_q > DIVIDEND_W'(SPEED_MAX)) ? SPEED_MAX : div_q[13:0];
    steer_abs = (mag_r > STEER_LIM) ? STEER_LIM : mag_r;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      logic_en_r  <= 1'b1;
      req_odom_r  <= 1'b1;
      cruise_r    <= 14'd350;
      stop_r      <= 16'd350;
      slow_cfg_r  <= 16'd900;
      max_steer_r <= 11'd450;
      gain_r      <= 12'd230;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOGIC_EN:   logic_en_r  <= cfg_wdata[0];
        CFG_REQ_ODOM:   req_odom_r  <= cfg_wdata[0];
        CFG_CRUISE:     cruise_r    <= cfg_wdata[13:0];
        CFG_STOP_DIST:  stop_r      <= cfg_wdata;
        CFG_SLOW_DIST:  slow_cfg_r  <= cfg_wdata;
        CFG_MAX_STEER:  max_steer_r <= cfg_wdata[10:0];
        CFG_STEER_GAIN: gain_r      <= cfg_wdata[11:0];
        default: begin
        end
      endcase
    end
  end

  // Scan accumulators and committed results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmin_r   <= '1;
      fseen_r  <= 1'b0;
      lsum_r   <= '0;
      lcnt_r   <= '0;
      rsum_r   <= '0;
      rcnt_r   <= '0;
      front_r  <= '1;
      fvalid_r <= 1'b0;
      lclr_r   <= '0;
      rclr_r   <= '0;
    end else begin
      case (cmd.op)
        OP_ACC: begin
          if (in_front) begin
            if (item_r.range_mm < fmin_r) begin
              fmin_r <= item_r.range_mm;
            end
            fseen_r <= 1'b1;
          end
          if (in_left) begin
            lsum_r <= lsum_r + 32'(val);
            lcnt_r <= lcnt_r + 1'b1;
          end
          if (in_right) begin
            rsum_r <= rsum_r + 32'(val);
            rcnt_r <= rcnt_r + 1'b1;
          end
        end
        OP_WAITL: begin
          if (div_done) begin
            lclr_r <= (lcnt_r == '0) ? 16'd0 : div_q[15:0];
          end
        end
        OP_WAITR: begin
          if (div_done) begin
            rclr_r <= (rcnt_r == '0) ? 16'd0 : div_q[15:0];
          end
        end
        OP_COMMIT: begin
          front_r  <= fmin_r;
          fvalid_r <= fseen_r;
          fmin_r   <= '1;
          fseen_r  <= 1'b0;
          lsum_r   <= '0;
          lcnt_r   <= '0;
          rsum_r   <= '0;
          rcnt_r   <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Item capture and tick arithmetic.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: item_r <= in_data;
      OP_GATE: begin
        res_r.speed_mm_s    <= '0;
        res_r.steering_mrad <= '0;
        res_r.reason_code   <= reason;
      end
      OP_STEER_MUL: begin
        neg_r   <= neg;
        scale_r <= scale;
        prod_r  <= 28'(gain_r) * 28'(diff);
      end
      OP_STEER_WAIT: begin
        if (div_done) begin
          mag_r <= (div_q > DIVIDEND_W'(max_steer_r)) ? max_steer_r : div_q[10:0];
        end
      end
      OP_SPEED_MUL1: begin
        p1_r <= 31'(cruise_r) * 31'(n1);
        d1_r <= d1;
        n2_r <= n2;
        d2_r <= d2;
      end
      OP_SPEED_MUL2: begin
        p2_r <= 45'(p1_r) * 45'(n2_r);
        dd_r <= 31'(d1_r) * 31'(d2_r);
      end
      OP_SPEED_WAIT: begin
        if (div_done) begin
          res_r.speed_mm_s    <= spd_sat;
          res_r.steering_mrad <= neg_r ? -$signed({1'b0, steer_abs})
                                       : $signed({1'b0, steer_abs});
          res_r.reason_code   <= RSN_GAP_DRIVE;
        end
      end
      default: begin
      end
    endcase
    if (cmd.load_out) begin
      out_r <= res_r;
    end
  end

  always_comb begin
    status.is_tick   = item_r.req_type != REQ_SAMPLE;
    status.last      = item_r.last_sample;
    status.mode      = item_r.mode_autonomous;
    status.gate_stop = reason != RSN_GAP_DRIVE;
    status.div_done  = div_done;
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

// ===== rtl/core/lgs_ctrl.sv =====
// Controller state machine: sequences accumulate, commit, gating, steering
// and speed steps, and owns the handshakes. Uses lgs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lgs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire lgs_pkg::status_t status,
  output lgs_pkg::cmd_t         cmd
);
  import lgs_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.load_out  = 1'b0;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.op   = OP_CAPTURE;
        if (in_valid) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!status.is_tick) begin
          cmd.op    = OP_ACC;
          state_nxt = status.last ? S_DIVL : S_IDLE;
        end else if (!status.mode) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_GATE;
          state_nxt = status.gate_stop ? S_EMIT : S_STEER_MUL;
        end
      end
      S_DIVL: begin
        cmd.op    = OP_DIVL;
        state_nxt = S_WAITL;
      end
      S_WAITL: begin
        cmd.op = OP_WAITL;
        if (status.div_done) begin
          state_nxt = S_DIVR;
        end
      end
      S_DIVR: begin
        cmd.op    = OP_DIVR;
        state_nxt = S_WAITR;
      end
      S_WAITR: begin
        cmd.op = OP_WAITR;
        if (status.div_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.op    = OP_COMMIT;
        state_nxt = S_IDLE;
      end
      S_STEER_MUL: begin
        cmd.op    = OP_STEER_MUL;
        state_nxt = S_STEER_DIV;
      end
      S_STEER_DIV: begin
        cmd.op    = OP_STEER_DIV;
        state_nxt = S_STEER_WAIT;
      end
      S_STEER_WAIT: begin
        cmd.op = OP_STEER_WAIT;
        if (status.div_done) begin
          state_nxt = S_SPEED_MUL1;
        end
      end
      S_SPEED_MUL1: begin
        cmd.op    = OP_SPEED_MUL1;
        state_nxt = S_SPEED_MUL2;
      end
      S_SPEED_MUL2: begin
        cmd.op    = OP_SPEED_MUL2;
        state_nxt = S_SPEED_DIV;
      end
      S_SPEED_DIV: begin
        cmd.op    = OP_SPEED_DIV;
        state_nxt = S_SPEED_WAIT;
      end
      S_SPEED_WAIT: begin
        cmd.op = OP_SPEED_WAIT;
        if (status.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_emit_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result appeared outside the emit step");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_done |-> (state_r == S_WAITL || state_r == S_WAITR ||
                         state_r == S_STEER_WAIT || state_r == S_SPEED_WAIT))
    else $error("divider finished while nobody was waiting");

  a_commit_after_right: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COMMIT |-> $past(state_r == S_WAITR))
    else $error("commit without the right sector average");
`endif

endmodule
`default_nettype wire
